/* hw/rtl/min_plus_matrix_power_paths_unit_defines.svh */
// Assertion helpers for the checker of this block.
`ifndef MIN_PLUS_MATRIX_POWER_PATHS_UNIT_DEFINES_SVH
`define MIN_PLUS_MATRIX_POWER_PATHS_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define MPMP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mpmp assertion failed");

// Consequent checked in the cycle after the antecedent.
`define MPMP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mpmp assertion failed");

`endif

/* hw/rtl/mpmp_pkg.sv */
package mpmp_pkg;

	localparam int MAX_NODES_DEF = 16;
	localparam int DIST_BITS_DEF = 63;
	localparam int QUEUE_DEPTH   = 4;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_EDGE  = 2'd1;
	localparam logic [1:0] OP_RUN   = 2'd2;

	localparam logic [1:0] REG_NODE_COUNT  = 2'd0;
	localparam logic [1:0] REG_WALK_LENGTH = 2'd1;

	localparam logic [4:0]  NODE_COUNT_RST  = 5'd16;
	localparam logic [31:0] WALK_LENGTH_RST = 32'd1;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  from_node;
		logic [3:0]  to_node;
		logic [31:0] weight;
	} item_t;

endpackage

/* hw/rtl/min_plus_matrix_power_paths_unit.sv */
// Clears are handled in the idle state, edges pass through S_EDGE; a 4-deep queue sits in front.
// A run sets the accumulator to the identity over the n nodes in use, then for each bit of the
// walk length, low bit first, multiplies it by the base if the bit is set and squares the base.
// Each product skips infinite left-hand entries and copies all MAX_NODES*MAX_NODES cells back.
// The result register holds one beat; a run's report waits for it to be popped.
// Reset (arst_n low) empties queue and result, marks every base entry infinite, resets registers.
module min_plus_matrix_power_paths_unit #(
	parameter int MAX_NODES = mpmp_pkg::MAX_NODES_DEF,
	parameter int DIST_BITS = mpmp_pkg::DIST_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  kind,
	input  logic [3:0]  from_node,
	input  logic [3:0]  to_node,
	input  logic [31:0] edge_weight,
	output logic        empty,
	input  logic        pop,
	output logic [61:0] distance,
	output logic        reachable,
	output logic        overflow
);
	mpmp_pkg::item_t                q_item;
	logic                           q_valid, q_pop;
	logic [$clog2(MAX_NODES+1)-1:0] n_use;
	logic [31:0]                    walk_len;

	mpmp_front #(.MAX_NODES(MAX_NODES)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .push(push), .full(full), .kind(kind), .from_node(from_node),
		.to_node(to_node), .edge_weight(edge_weight), .q_item(q_item), .q_valid(q_valid),
		.q_pop(q_pop), .n_use(n_use), .walk_len(walk_len));

	mpmp_engine #(.MAX_NODES(MAX_NODES), .DIST_BITS(DIST_BITS)) u_engine (
		.clk(clk), .arst_n(arst_n), .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop),
		.n_use(n_use), .walk_len(walk_len), .empty(empty), .pop(pop), .distance(distance),
		.reachable(reachable), .overflow(overflow));
endmodule

/* hw/rtl/mpmp_ram.sv */
module mpmp_ram #(
	parameter int WIDTH = 63,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* hw/rtl/mpmp_front.sv */
module mpmp_front #(
	parameter int MAX_NODES = mpmp_pkg::MAX_NODES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [1:0]                       cfg_index,
	input  logic [31:0]                      cfg_data,
	input  logic                             push,
	output logic                             full,
	input  logic [1:0]                       kind,
	input  logic [3:0]                       from_node,
	input  logic [3:0]                       to_node,
	input  logic [31:0]                      edge_weight,
	output mpmp_pkg::item_t                  q_item,
	output logic                             q_valid,
	input  logic                             q_pop,
	output logic [$clog2(MAX_NODES+1)-1:0]   n_use,
	output logic [31:0]                      walk_len
);
	localparam int NW = $clog2(MAX_NODES + 1);
	localparam int QD = mpmp_pkg::QUEUE_DEPTH;
	localparam int PW = $clog2(QD);

	logic [4:0]      node_count_q;
	logic [31:0]     walk_length_q;
	mpmp_pkg::item_t buf_q [QD];
	logic [PW-1:0]   wr_q, rd_q;
	logic [PW:0]     cnt_q;
	logic            keep, enq, deq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q  <= mpmp_pkg::NODE_COUNT_RST;
			walk_length_q <= mpmp_pkg::WALK_LENGTH_RST;
		end else if (cfg_write) begin
			if (cfg_index == mpmp_pkg::REG_NODE_COUNT) begin
				node_count_q <= cfg_data[4:0];
			end else if (cfg_index == mpmp_pkg::REG_WALK_LENGTH) begin
				walk_length_q <= cfg_data;
			end
		end
	end

	always_comb begin
		if (node_count_q == 5'd0) begin
			n_use = NW'(1);
		end else if (32'(node_count_q) > MAX_NODES) begin
			n_use = NW'(MAX_NODES);
		end else begin
			n_use = NW'(node_count_q);
		end
	end
	assign walk_len = walk_length_q;

	// Unknown kinds and edges outside the nodes in use are accepted and dropped here.
	always_comb begin
		keep = 1'b0;
		if (kind == mpmp_pkg::OP_CLEAR || kind == mpmp_pkg::OP_RUN) begin
			keep = 1'b1;
		end else if (kind == mpmp_pkg::OP_EDGE) begin
			keep = (32'(from_node) < 32'(n_use)) && (32'(to_node) < 32'(n_use));
		end
	end

	assign full    = (cnt_q == (PW+1)'(QD));
	assign q_valid = (cnt_q != '0);
	assign q_item  = buf_q[rd_q];
	assign enq     = push && !full && keep;
	assign deq     = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (enq) begin
			buf_q[wr_q] <= '{op: kind, from_node: from_node, to_node: to_node,
				weight: edge_weight};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (enq) begin
				wr_q <= wr_q + PW'(1);
			end
			if (deq) begin
				rd_q <= rd_q + PW'(1);
			end
			if (enq && !deq) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (deq && !enq) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end
endmodule

/* hw/rtl/mpmp_engine.sv */
module mpmp_engine #(
	parameter int MAX_NODES = mpmp_pkg::MAX_NODES_DEF,
	parameter int DIST_BITS = mpmp_pkg::DIST_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mpmp_pkg::item_t                q_item,
	input  logic                           q_valid,
	output logic                           q_pop,
	input  logic [$clog2(MAX_NODES+1)-1:0] n_use,
	input  logic [31:0]                    walk_len,
	output logic                           empty,
	input  logic                           pop,
	output logic [61:0]                    distance,
	output logic                           reachable,
	output logic                           overflow
);
	localparam int NW    = $clog2(MAX_NODES + 1);
	localparam int NB    = $clog2(MAX_NODES);
	localparam int CELLS = MAX_NODES * MAX_NODES;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(CELLS + 1);
	localparam int D     = DIST_BITS;
	localparam logic [D-1:0] INF  = {1'b1, {(D-1){1'b0}}};
	localparam logic [D-1:0] MAXF = {1'b0, {(D-1){1'b1}}};

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_EDGE   = 4'd1;
	localparam logic [3:0] S_AINIT  = 4'd2;
	localparam logic [3:0] S_STEP   = 4'd3;
	localparam logic [3:0] S_SINIT  = 4'd4;
	localparam logic [3:0] S_ARD    = 4'd5;
	localparam logic [3:0] S_ALAT   = 4'd6;
	localparam logic [3:0] S_BRD    = 4'd7;
	localparam logic [3:0] S_BCALC  = 4'd8;
	localparam logic [3:0] S_COPY   = 4'd9;
	localparam logic [3:0] S_RPT_RD = 4'd10;
	localparam logic [3:0] S_RPT    = 4'd11;

	logic [3:0]    state_q;
	logic [NB-1:0] ii_q, jj_q, kk_q, last;
	logic [CW-1:0] cpy_q;
	logic          acc_q, ovf_q;
	logic [31:0]   exp_q;
	logic [D-1:0]  x_q;
	logic [AW-1:0] ea_q;
	logic [D-1:0]  ew_q;
	logic          res_valid_q, reach_q, res_ovf_q;
	logic [61:0]   dist_q;

	logic [CELLS-1:0] base_vld_q;
	logic             base_vld_s1;
	logic             b_we, a_we, s_we;
	logic [AW-1:0]    b_wa, a_wa, s_wa, b_ra, a_ra, s_ra;
	logic [D-1:0]     b_wd, a_wd, s_wd, b_raw, a_rd, s_rd, b_rd;
	logic [D-1:0]     sum, w_sat, x_rd;
	logic             sat, upd, s_inf;

	function automatic logic [AW-1:0] cell_addr(input logic [NB-1:0] r, input logic [NB-1:0] c);
		cell_addr = AW'(AW'(r) * AW'(MAX_NODES) + AW'(c));
	endfunction

	assign last = NB'(n_use - NW'(1));

	mpmp_ram #(.WIDTH(D), .DEPTH(CELLS)) u_base (
		.clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_raw));
	mpmp_ram #(.WIDTH(D), .DEPTH(CELLS)) u_accum (
		.clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));
	mpmp_ram #(.WIDTH(D), .DEPTH(CELLS)) u_scratch (
		.clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

	// Base entries never written since the last clear read as infinity.
	assign b_rd = base_vld_s1 ? b_raw : INF;
	assign x_rd = acc_q ? a_rd : b_rd;

	always_comb begin
		if (64'(q_item.weight) > 64'(MAXF)) begin
			w_sat = MAXF;
		end else begin
			w_sat = D'(q_item.weight);
		end
	end

	// When both operands are finite the sum fits in D bits; the top bit then flags saturation.
	assign sum   = x_q + b_rd;
	assign sat   = sum[D-1];
	assign s_inf = s_rd[D-1];
	assign upd   = !b_rd[D-1] && (s_inf || (sat ? MAXF : sum) < s_rd);

	always_comb begin
		b_ra = '0;
		a_ra = '0;
		s_ra = '0;
		unique case (state_q)
			S_IDLE:   b_ra = cell_addr(NB'(q_item.from_node), NB'(q_item.to_node));
			S_ARD: begin
				b_ra = cell_addr(ii_q, jj_q);
				a_ra = cell_addr(ii_q, jj_q);
			end
			S_BRD: begin
				b_ra = cell_addr(jj_q, kk_q);
				s_ra = cell_addr(ii_q, kk_q);
			end
			S_COPY:   s_ra = AW'(cpy_q);
			S_RPT_RD: a_ra = cell_addr('0, last);
			S_RPT:    a_ra = cell_addr('0, last);
			default: ;
		endcase
	end

	always_comb begin
		b_we = 1'b0;
		b_wa = ea_q;
		b_wd = ew_q;
		a_we = 1'b0;
		a_wa = cell_addr(ii_q, jj_q);
		a_wd = (ii_q == jj_q) ? '0 : INF;
		s_we = 1'b0;
		s_wa = cell_addr(ii_q, kk_q);
		s_wd = INF;
		unique case (state_q)
			S_EDGE:  b_we = b_rd[D-1] || (ew_q < b_rd);
			S_AINIT: a_we = 1'b1;
			S_SINIT: s_we = 1'b1;
			S_BCALC: begin
				s_we = upd;
				s_wd = sat ? MAXF : sum;
			end
			S_COPY: begin
				b_we = !acc_q && (cpy_q != '0);
				a_we = acc_q && (cpy_q != '0);
				b_wa = AW'(cpy_q - CW'(1));
				a_wa = AW'(cpy_q - CW'(1));
				b_wd = s_rd;
				a_wd = s_rd;
			end
			default: ;
		endcase
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_vld_q  <= '0;
			base_vld_s1 <= 1'b0;
		end else begin
			base_vld_s1 <= base_vld_q[b_ra];
			if (q_pop && q_item.op == mpmp_pkg::OP_CLEAR) begin
				base_vld_q <= '0;
			end else if (b_we) begin
				base_vld_q[b_wa] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ea_q <= cell_addr(NB'(q_item.from_node), NB'(q_item.to_node));
			ew_q <= w_sat;
		end
		if (state_q == S_ALAT) begin
			x_q <= x_rd;
		end
		if (state_q == S_RPT && !res_valid_q) begin
			dist_q  <= a_rd[D-1] ? '0 : 62'(a_rd[D-2:0]);
			reach_q <= !a_rd[D-1];
			res_ovf_q <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ii_q        <= '0;
			jj_q        <= '0;
			kk_q        <= '0;
			cpy_q       <= '0;
			acc_q       <= 1'b0;
			ovf_q       <= 1'b0;
			exp_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						if (q_item.op == mpmp_pkg::OP_EDGE) begin
							state_q <= S_EDGE;
						end else if (q_item.op == mpmp_pkg::OP_RUN) begin
							ovf_q   <= 1'b0;
							exp_q   <= walk_len;
							ii_q    <= '0;
							jj_q    <= '0;
							state_q <= S_AINIT;
						end
					end
				end
				S_EDGE: state_q <= S_IDLE;
				S_AINIT: begin
					if (jj_q == last) begin
						jj_q <= '0;
						if (ii_q == last) begin
							state_q <= S_STEP;
						end else begin
							ii_q <= ii_q + NB'(1);
						end
					end else begin
						jj_q <= jj_q + NB'(1);
					end
				end
				S_STEP: begin
					ii_q <= '0;
					kk_q <= '0;
					if (exp_q == '0) begin
						state_q <= S_RPT_RD;
					end else begin
						acc_q   <= exp_q[0];
						state_q <= S_SINIT;
					end
				end
				S_SINIT: begin
					if (kk_q == last) begin
						kk_q <= '0;
						if (ii_q == last) begin
							ii_q    <= '0;
							jj_q    <= '0;
							state_q <= S_ARD;
						end else begin
							ii_q <= ii_q + NB'(1);
						end
					end else begin
						kk_q <= kk_q + NB'(1);
					end
				end
				S_ARD: state_q <= S_ALAT;
				S_ALAT, S_BCALC: begin
					if (state_q == S_BCALC && sat && !b_rd[D-1]) begin
						ovf_q <= 1'b1;
					end
					if (state_q == S_ALAT && !x_rd[D-1]) begin
						kk_q    <= '0;
						state_q <= S_BRD;
					end else if (state_q == S_BCALC && kk_q != last) begin
						kk_q    <= kk_q + NB'(1);
						state_q <= S_BRD;
					end else if (jj_q != last) begin
						jj_q    <= jj_q + NB'(1);
						state_q <= S_ARD;
					end else if (ii_q != last) begin
						ii_q    <= ii_q + NB'(1);
						jj_q    <= '0;
						state_q <= S_ARD;
					end else begin
						cpy_q   <= '0;
						state_q <= S_COPY;
					end
				end
				S_BRD: state_q <= S_BCALC;
				S_COPY: begin
					if (cpy_q == CW'(CELLS)) begin
						ii_q <= '0;
						kk_q <= '0;
						if (acc_q) begin
							acc_q   <= 1'b0;
							state_q <= S_SINIT;
						end else begin
							exp_q   <= exp_q >> 1;
							state_q <= S_STEP;
						end
					end else begin
						cpy_q <= cpy_q + CW'(1);
					end
				end
				S_RPT_RD: state_q <= S_RPT;
				S_RPT: begin
					if (!res_valid_q) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign empty     = !res_valid_q;
	assign distance  = dist_q;
	assign reachable = reach_q;
	assign overflow  = res_ovf_q;
endmodule

/* hw/rtl/mpmp_checker.sv */
`include "min_plus_matrix_power_paths_unit_defines.svh"

module mpmp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [61:0] distance,
	input logic        reachable
);
	// A waiting result beat must not change until it is taken.
	`MPMP_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(distance) && $stable(reachable))
	// An unreachable answer always reports a zero distance.
	`MPMP_ASSERT_NOW(a_unreach_zero, !empty && !reachable, distance == 62'd0)
	// The result stage holds one beat, so the stage is empty in the cycle after it is taken.
	`MPMP_ASSERT_NEXT(a_pop_empties, !empty && pop, empty)
endmodule

bind min_plus_matrix_power_paths_unit mpmp_checker u_mpmp_checker (.*);

/* tb/min_plus_matrix_power_paths_unit_checker.sv */
module min_plus_matrix_power_paths_unit_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        push,
	input  logic        full,
	input  logic [1:0]  kind,
	input  logic [3:0]  from_node,
	input  logic [3:0]  to_node,
	input  logic [31:0] edge_weight,
	input  logic        empty,
	input  logic        pop,
	input  logic [61:0] distance,
	input  logic        reachable,
	input  logic        overflow,
	output int          errors,
	output int          pending,
	output int          answers_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NN = mpmp_pkg::MAX_NODES_DEF;
	localparam bit [62:0] INF = 63'd1 << 62;
	localparam bit [62:0] MAXF = INF - 63'd1;

	typedef struct {
		bit [61:0] walk_dist;
		bit        reach;
		bit        ovf;
	} walk_answer_t;

	walk_answer_t answers_due[$];

	bit [62:0] adjacency [NN*NN];
	bit [62:0] power_acc [NN*NN];
	bit [62:0] product_buf [NN*NN];
	bit [4:0]  nodes_reg;
	bit [31:0] length_reg;
	bit        sat_seen;

	function automatic int active_nodes();
		if (nodes_reg == 0) return 1;
		if (nodes_reg > NN) return NN;
		return int'(nodes_reg);
	endfunction

	// The product buffer persists; its whole contents land in the destination,
	// so entries beyond the nodes in use carry over exactly as the block keeps them.
	task automatic minplus_product(input bit into_acc, input int n);
		bit [62:0] lhs [NN*NN];
		bit [62:0] x, y, s;
		int i, j, k;
		if (into_acc) lhs = power_acc;
		else lhs = adjacency;
		for (i = 0; i < n; i++)
			for (k = 0; k < n; k++)
				product_buf[i*NN+k] = INF;
		for (i = 0; i < n; i++) begin
			for (j = 0; j < n; j++) begin
				x = lhs[i*NN+j];
				if (x[62]) continue;
				for (k = 0; k < n; k++) begin
					y = adjacency[j*NN+k];
					if (y[62]) continue;
					s = x + y;
					if (s > MAXF) begin
						s = MAXF;
						sat_seen = 1'b1;
					end
					if (product_buf[i*NN+k][62] || s < product_buf[i*NN+k])
						product_buf[i*NN+k] = s;
				end
			end
		end
		if (into_acc) power_acc = product_buf;
		else adjacency = product_buf;
	endtask

	task automatic predict_beat(input logic [1:0] op, input logic [3:0] src,
			input logic [3:0] dst, input logic [31:0] w);
		int n, i, j;
		bit [31:0] left;
		bit [62:0] e, wv;
		walk_answer_t ans;
		n = active_nodes();
		if (op == mpmp_pkg::OP_CLEAR) begin
			foreach (adjacency[i]) adjacency[i] = INF;
		end else if (op == mpmp_pkg::OP_EDGE) begin
			if (int'(src) < n && int'(dst) < n) begin
				wv = 63'(w);
				if (wv > MAXF) wv = MAXF;
				if (adjacency[src*NN+dst][62] || wv < adjacency[src*NN+dst])
					adjacency[src*NN+dst] = wv;
			end
		end else if (op == mpmp_pkg::OP_RUN) begin
			sat_seen = 1'b0;
			for (i = 0; i < n; i++)
				for (j = 0; j < n; j++)
					power_acc[i*NN+j] = (i == j) ? 63'd0 : INF;
			left = length_reg;
			while (left != 0) begin
				if (left[0]) minplus_product(1'b1, n);
				minplus_product(1'b0, n);
				left >>= 1;
			end
			e = power_acc[n-1];
			ans.reach = !e[62];
			ans.walk_dist = e[62] ? 62'd0 : e[61:0];
			ans.ovf = sat_seen;
			answers_due.push_back(ans);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		walk_answer_t exp_ans;
		if (!arst_n) begin
			foreach (adjacency[i]) adjacency[i] = INF;
			foreach (power_acc[i]) power_acc[i] = '0;
			foreach (product_buf[i]) product_buf[i] = '0;
			nodes_reg = mpmp_pkg::NODE_COUNT_RST;
			length_reg = mpmp_pkg::WALK_LENGTH_RST;
			sat_seen = 1'b0;
			answers_due.delete();
			errors = 0;
			pending = 0;
			answers_checked = 0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == mpmp_pkg::REG_NODE_COUNT) nodes_reg = cfg_data[4:0];
				else if (cfg_index == mpmp_pkg::REG_WALK_LENGTH) length_reg = cfg_data;
			end
			if (pop && !empty) begin
				if (answers_due.size() == 0) begin
					$error("result beat with no expectation waiting");
					errors++;
				end else begin
					exp_ans = answers_due.pop_front();
					answers_checked++;
					if (distance !== exp_ans.walk_dist) begin
						$error("distance: expected %0d, actual %0d", exp_ans.walk_dist, distance);
						errors++;
					end
					if (reachable !== exp_ans.reach) begin
						$error("reachable: expected %0d, actual %0d", exp_ans.reach, reachable);
						errors++;
					end
					if (overflow !== exp_ans.ovf) begin
						$error("overflow: expected %0d, actual %0d", exp_ans.ovf, overflow);
						errors++;
					end
				end
			end
			if (push && !full) predict_beat(kind, from_node, to_node, edge_weight);
			pending = answers_due.size();
		end
	end

endmodule

/* tb/min_plus_matrix_power_paths_unit_tb.sv */
module min_plus_matrix_power_paths_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CYCLE_LIMIT = 20000000;
	localparam logic [1:0] KIND_UNKNOWN = 2'd3;
	localparam logic [1:0] REG_SPARE_LO = 2'd2;
	localparam logic [1:0] REG_SPARE_HI = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        push;
	logic        full;
	logic [1:0]  kind;
	logic [3:0]  from_node;
	logic [3:0]  to_node;
	logic [31:0] edge_weight;
	logic        empty;
	logic        pop;
	logic [61:0] distance;
	logic        reachable;
	logic        overflow;

	int     errors, pending, answers_checked;
	int     beats_sent, runs_sent;
	longint cycle_count;
	bit     calm;
	bit     hold_request;

	min_plus_matrix_power_paths_unit uut (.*);

	min_plus_matrix_power_paths_unit_checker checker_i (.*);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("min_plus_matrix_power_paths_unit regression: fail");
				$finish;
			end
		end
	end

	// Result side: random stalls, none while calm, and one long hold-off on request.
	initial begin
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				pop <= 1'b0;
				repeat (300) @(posedge clk);
				hold_request = 1'b0;
			end
			pop <= calm || ($urandom_range(99) >= 24);
		end
	end

	task automatic send_beat(input logic [1:0] op, input logic [3:0] src,
			input logic [3:0] dst, input logic [31:0] w);
		while (!calm && $urandom_range(99) < 24) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		kind <= op;
		from_node <= src;
		to_node <= dst;
		edge_weight <= w;
		do @(posedge clk); while (full);
		beats_sent++;
		if (op == mpmp_pkg::OP_RUN) runs_sent++;
	endtask

	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Also pokes the unused indexes, which the block must ignore.
	task automatic write_regs(input logic [31:0] nodes, input logic [31:0] steps);
		cfg_write <= 1'b1;
		cfg_index <= mpmp_pkg::REG_NODE_COUNT;
		cfg_data <= nodes;
		@(posedge clk);
		cfg_index <= mpmp_pkg::REG_WALK_LENGTH;
		cfg_data <= steps;
		@(posedge clk);
		cfg_index <= REG_SPARE_LO;
		cfg_data <= $urandom;
		@(posedge clk);
		cfg_index <= REG_SPARE_HI;
		cfg_data <= $urandom;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_weight();
		case ($urandom_range(9))
			0: return 32'hFFFF_FFFF;
			1: return 32'd0;
			2, 3: return $urandom;
			default: return $urandom_range(50);
		endcase
	endfunction

	initial begin
		int n, i, k, span;
		logic [31:0] nodes_w, steps_w;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		push = 1'b0;
		kind = '0;
		from_node = '0;
		to_node = '0;
		edge_weight = '0;
		calm = 1'b0;
		hold_request = 1'b0;
		beats_sent = 0;
		runs_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, repeated edge keeps the smaller weight.
		send_beat(mpmp_pkg::OP_EDGE, 4'd0, 4'd15, 32'hFFFF_FFFF);
		send_beat(mpmp_pkg::OP_EDGE, 4'd0, 4'd15, 32'd5);
		send_beat(mpmp_pkg::OP_EDGE, 4'd0, 4'd15, 32'd9);
		send_beat(mpmp_pkg::OP_RUN, 4'd0, 4'd0, 32'd0);
		send_beat(mpmp_pkg::OP_RUN, 4'd0, 4'd0, 32'd0);
		send_beat(KIND_UNKNOWN, 4'd15, 4'd15, 32'hFFFF_FFFF);
		send_beat(mpmp_pkg::OP_CLEAR, 4'd0, 4'd0, 32'd0);
		send_beat(mpmp_pkg::OP_RUN, 4'd0, 4'd0, 32'd0);
		settle();
		// Node count 3, walk length 2; edges beyond the nodes in use are dropped.
		write_regs(32'hFFFF_FFE3, 32'd2);
		send_beat(mpmp_pkg::OP_CLEAR, 4'd0, 4'd0, 32'd0);
		send_beat(mpmp_pkg::OP_EDGE, 4'd0, 4'd1, 32'd7);
		send_beat(mpmp_pkg::OP_EDGE, 4'd1, 4'd2, 32'd8);
		send_beat(mpmp_pkg::OP_EDGE, 4'd5, 4'd2, 32'd0);
		send_beat(mpmp_pkg::OP_EDGE, 4'd0, 4'd9, 32'd0);
		send_beat(mpmp_pkg::OP_RUN, 4'd0, 4'd0, 32'd0);
		settle();
		// Zero walk length with a node count of zero, which acts as one.
		write_regs(32'd0, 32'd0);
		send_beat(mpmp_pkg::OP_RUN, 4'd0, 4'd0, 32'd0);
		settle();
		write_regs(32'd2, 32'd0);
		send_beat(mpmp_pkg::OP_RUN, 4'd0, 4'd0, 32'd0);
		settle();
		// Largest exponent on a full heavy cycle: sums saturate.
		write_regs(32'd31, 32'hFFFF_FFFF);
		send_beat(mpmp_pkg::OP_CLEAR, 4'd0, 4'd0, 32'd0);
		for (i = 0; i < 16; i++)
			send_beat(mpmp_pkg::OP_EDGE, i[3:0], 4'(i + 1), 32'hFFFF_FFFF);
		send_beat(mpmp_pkg::OP_EDGE, 4'd0, 4'd0, 32'hFFFF_FFFF);
		send_beat(mpmp_pkg::OP_RUN, 4'd0, 4'd0, 32'd0);
		settle();

		// Receiver holds off while loads and runs pile up behind it.
		write_regs(32'd3, 32'd3);
		hold_request = 1'b1;
		send_beat(mpmp_pkg::OP_CLEAR, 4'd0, 4'd0, 32'd0);
		for (i = 0; i < 12; i++) begin
			send_beat(mpmp_pkg::OP_EDGE, 4'($urandom_range(2)), 4'($urandom_range(2)),
				pick_weight());
			send_beat(mpmp_pkg::OP_RUN, 4'd0, 4'd0, 32'd0);
		end
		settle();

		k = 0;
		while (beats_sent < 440) begin
			calm = (k % 7 == 3);
			case ($urandom_range(9))
				0: nodes_w = {27'($urandom), 5'($urandom_range(16, 31))};
				1: nodes_w = 32'd16;
				default: nodes_w = $urandom_range(1, 6);
			endcase
			case ($urandom_range(11))
				0: steps_w = $urandom;
				1: steps_w = 32'd0;
				default: steps_w = $urandom_range(1, 20);
			endcase
			if (steps_w > 32'd1000 && nodes_w > 6) nodes_w = $urandom_range(1, 4);
			write_regs(nodes_w, steps_w);
			n = (nodes_w[4:0] == 0) ? 1 : (nodes_w[4:0] > 16) ? 16 : int'(nodes_w[4:0]);
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(4) != 0)
					send_beat(mpmp_pkg::OP_CLEAR, 4'($urandom), 4'($urandom), $urandom);
				span = $urandom_range(1, 2 * n + 2);
				for (i = 0; i < span; i++) begin
					if ($urandom_range(9) == 0)
						send_beat(mpmp_pkg::OP_EDGE, 4'($urandom), 4'($urandom), pick_weight());
					else if ($urandom_range(19) == 0)
						send_beat(KIND_UNKNOWN, 4'($urandom), 4'($urandom), $urandom);
					else
						send_beat(mpmp_pkg::OP_EDGE, 4'($urandom_range(n - 1)),
							4'($urandom_range(n - 1)), pick_weight());
				end
				send_beat(mpmp_pkg::OP_RUN, 4'($urandom), 4'($urandom), $urandom);
			end
			settle();
			k++;
		end
		calm = 1'b0;

		repeat (50) @(posedge clk);
		$display("Covered %0d input beats, %0d of them runs; %0d results compared.",
			beats_sent, runs_sent, answers_checked);
		if (errors == 0 && pending == 0)
			$display("min_plus_matrix_power_paths_unit regression: pass");
		else
			$display("min_plus_matrix_power_paths_unit regression: fail");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/mpmp_pkg.sv
hw/rtl/mpmp_ram.sv
hw/rtl/mpmp_front.sv
hw/rtl/mpmp_engine.sv
hw/rtl/min_plus_matrix_power_paths_unit.sv
hw/rtl/mpmp_checker.sv
tb/min_plus_matrix_power_paths_unit_checker.sv
tb/min_plus_matrix_power_paths_unit_tb.sv
